FILE: design/lzwc_pkg.sv
`default_nettype none
package lzwc_pkg;
  localparam int unsigned CodeBits = 12;
  localparam int unsigned DictEntries = 4096;
  localparam int unsigned ByteCodes = 256;
  localparam int unsigned HashBits = 12;
  localparam int unsigned HashDepth = 1 << HashBits;
  localparam int unsigned LimBits = 13;
  // Stream tag per bucket; tag 0 is never live, so a swept bucket reads empty
  localparam int unsigned EpochBits = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic [CodeBits-1:0] code_word;
    logic                last_code;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_EMIT_PREFIX,
    ST_EMIT_LAST
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic probe;
    logic advance;
    logic take_hit;
    logic insert;
    logic load_byte;
    logic out_prefix;
    logic out_last;
    logic clear;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic have_prefix;
    logic eos;
    logic hit;
    logic miss;
    logic room;
    logic swept;
  } dp_status_t;

  // Bucket index of a (prefix, byte) pair.
  function automatic logic [HashBits-1:0] pair_hash(input logic [CodeBits-1:0] pre,
                                                    input logic [7:0] b);
    logic [HashBits-1:0] r;
    r = HashBits'(pre) ^ HashBits'({b, 4'b0}) ^ HashBits'(b);
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: design/lzwc_datapath.sv
`default_nettype none
// Holds prefix, code counter and a hash table with linear probing.
// Each bucket stores {epoch, prefix, byte, code}; a bucket whose epoch differs
// from the current one reads as empty. Epoch 0 is reserved for swept buckets.
module lzwc_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lzwc_pkg::in_beat_t          in_beat_i,
  input  wire logic [lzwc_pkg::LimBits-1:0] dict_limit_i,
  input  wire lzwc_pkg::dp_cmd_t           cmd_i,
  output lzwc_pkg::dp_status_t             status_o,
  output lzwc_pkg::out_beat_t              out_beat_o
);
  localparam int unsigned CB = lzwc_pkg::CodeBits;
  localparam int unsigned HB = lzwc_pkg::HashBits;
  localparam int unsigned LB = lzwc_pkg::LimBits;
  localparam int unsigned EB = lzwc_pkg::EpochBits;
  localparam int unsigned EntW = EB + CB + 8 + CB;

  logic [7:0]    byte_q;
  logic          eos_q;
  logic [CB-1:0] prefix_q, prefix_d;
  logic          have_q, have_d;
  logic [LB-1:0] next_q, next_d;
  logic [EB-1:0] epoch_q;
  logic [HB-1:0] slot_q, slot_d;
  logic [EntW-1:0] rd_q;
  logic [EntW-1:0] mem [lzwc_pkg::HashDepth];

  // Sweep after reset, and again whenever the epoch wraps
  logic [HB:0] sweep_q;
  logic        sweeping;
  assign sweeping = !sweep_q[HB];

  logic [LB-1:0] lim_eff;
  assign lim_eff = (dict_limit_i > LB'(lzwc_pkg::DictEntries)) ?
                   LB'(lzwc_pkg::DictEntries) : dict_limit_i;

  logic [EB-1:0] e_epoch;
  logic [CB-1:0] e_pre, e_code;
  logic [7:0]    e_byte;
  assign {e_epoch, e_pre, e_byte, e_code} = rd_q;
  logic e_live;
  assign e_live = (e_epoch == epoch_q);

  assign status_o.have_prefix = have_q;
  assign status_o.eos  = eos_q;
  assign status_o.hit  = e_live && e_pre == prefix_q && e_byte == byte_q;
  assign status_o.miss = !e_live || sweeping;
  assign status_o.room = next_q < lim_eff;
  assign status_o.swept = !sweeping;

  // Memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (sweeping) begin
      mem[sweep_q[HB-1:0]] <= '0;
    end else if (cmd_i.insert) begin
      mem[slot_q] <= {epoch_q, prefix_q, byte_q, next_q[CB-1:0]};
    end
    rd_q <= mem[slot_d];
  end

  // Probe address
  always_comb begin
    slot_d = slot_q;
    if (cmd_i.load_in) begin
      slot_d = lzwc_pkg::pair_hash(prefix_q, in_beat_i.data_byte);
    end else if (cmd_i.advance) begin
      slot_d = slot_q + HB'(1);
    end
  end

  // Prefix and counter
  always_comb begin
    prefix_d = prefix_q;
    have_d   = have_q;
    next_d   = next_q;
    if (cmd_i.take_hit) prefix_d = e_code;
    if (cmd_i.insert)   next_d = next_q + LB'(1);
    if (cmd_i.load_byte) begin
      prefix_d = CB'(byte_q);
      have_d   = 1'b1;
    end
    if (cmd_i.clear) begin
      prefix_d = '0;
      have_d   = 1'b0;
      next_d   = LB'(lzwc_pkg::ByteCodes);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
      have_q   <= 1'b0;
      next_q   <= LB'(lzwc_pkg::ByteCodes);
      epoch_q  <= EB'(1);
      sweep_q  <= '0;
      slot_q   <= '0;
    end else begin
      prefix_q <= prefix_d;
      have_q   <= have_d;
      next_q   <= next_d;
      slot_q   <= slot_d;
      // epoch wrap restarts the sweep so stale tags never come back to life
      if (cmd_i.clear && epoch_q == '1) begin
        sweep_q <= '0;
      end else if (sweeping) begin
        sweep_q <= sweep_q + (HB+1)'(1);
      end
      if (cmd_i.clear) begin
        epoch_q <= (epoch_q == '1) ? EB'(1) : epoch_q + EB'(1);
      end
    end
  end

  // Input beat capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      byte_q <= in_beat_i.data_byte;
      eos_q  <= in_beat_i.end_of_stream;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_prefix) begin
      out_beat_o <= '{code_word: prefix_q, last_code: 1'b0};
    end else if (cmd_i.out_last) begin
      out_beat_o <= '{code_word: prefix_q, last_code: 1'b1};
    end
  end

  logic busy_sweep;
  assign busy_sweep = sweeping;
  a_no_insert_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_sweep |-> !cmd_i.insert) else $error("insert during sweep");
  a_next_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= LB'(lzwc_pkg::DictEntries)) else $error("code counter overflow");
  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> !have_q && next_q == LB'(lzwc_pkg::ByteCodes))
    else $error("clear failed");
endmodule
`default_nettype wire

FILE: design/lzwc_ctrl.sv
`default_nettype none
module lzwc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire logic               sweep_done_i,
  input  wire lzwc_pkg::dp_status_t status_i,
  output lzwc_pkg::dp_cmd_t       cmd_o
);
  lzwc_pkg::ctrl_state_e state_q, state_d;
  logic ov_q, ov_d;
  logic out_free;
  assign out_free = !ov_q || !out_stall_i;
  assign out_valid_o = ov_q;
  assign in_stall_o = !(state_q == lzwc_pkg::ST_IDLE && sweep_done_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lzwc_pkg::ST_IDLE: begin
        if (in_valid_i && sweep_done_i) begin
          state_d = lzwc_pkg::ST_PROBE;
        end
      end
      lzwc_pkg::ST_PROBE: state_d = lzwc_pkg::ST_CHECK;
      lzwc_pkg::ST_CHECK: begin
        if (!status_i.have_prefix) begin
          state_d = status_i.eos ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
        end else if (status_i.hit) begin
          state_d = status_i.eos ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
        end else if (status_i.miss) begin
          state_d = lzwc_pkg::ST_EMIT_PREFIX;
        end else begin
          state_d = lzwc_pkg::ST_CHECK;
        end
      end
      lzwc_pkg::ST_EMIT_PREFIX: begin
        if (out_free) begin
          state_d = status_i.eos ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
        end
      end
      lzwc_pkg::ST_EMIT_LAST: if (out_free) state_d = lzwc_pkg::ST_IDLE;
      default: state_d = lzwc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    ov_d = ov_q && out_stall_i;
    case (state_q)
      lzwc_pkg::ST_IDLE: cmd_o.load_in = in_valid_i && sweep_done_i;
      lzwc_pkg::ST_PROBE: cmd_o.probe = 1'b1;
      lzwc_pkg::ST_CHECK: begin
        if (!status_i.have_prefix) begin
          cmd_o.load_byte = 1'b1;
        end else if (status_i.hit) begin
          cmd_o.take_hit = 1'b1;
        end else if (!status_i.miss) begin
          cmd_o.advance = 1'b1;
        end
      end
      lzwc_pkg::ST_EMIT_PREFIX: begin
        if (out_free) begin
          cmd_o.out_prefix = 1'b1;
          cmd_o.insert     = status_i.room;
          cmd_o.load_byte  = 1'b1;
          ov_d = 1'b1;
        end
      end
      lzwc_pkg::ST_EMIT_LAST: begin
        if (out_free) begin
          cmd_o.out_last = 1'b1;
          cmd_o.clear    = 1'b1;
          ov_d = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzwc_pkg::ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  a_emit_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_prefix || cmd_o.out_last) |-> out_free) else $error("output overrun");
  a_emit_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.out_prefix && cmd_o.out_last)) else $error("double emit");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_in |=> state_q == lzwc_pkg::ST_PROBE) else $error("bad load");
endmodule
`default_nettype wire

FILE: design/lzw_byte_compressor.sv
`default_nettype none
// LZW compressor, 12-bit codes, hashed dictionary with linear probing.
// Each byte is accepted in IDLE, then passes PROBE and CHECK; CHECK repeats for each
// extra probe, and each code emitted adds an EMIT state that waits out any output stall.
// A new byte is taken only back in IDLE; a code is registered as its EMIT state is left.
// Reset: asynchronous active low, then a sweep empties the table with no
// byte taken; end of stream steps the epoch, and every 255th one repeats the sweep.
module lzw_byte_compressor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lzwc_pkg::LimBits-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire lzwc_pkg::in_beat_t          in_beat_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output lzwc_pkg::out_beat_t              out_beat_o
);
  logic [lzwc_pkg::LimBits-1:0] dict_limit_q;
  lzwc_pkg::dp_cmd_t    cmd;
  lzwc_pkg::dp_status_t status;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dict_limit_q <= lzwc_pkg::LimBits'(lzwc_pkg::DictEntries);
    end else if (cfg_we_i) begin
      dict_limit_q <= cfg_wdata_i;
    end
  end

  lzwc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sweep_done_i(status.swept),
    .status_i(status), .cmd_o(cmd)
  );

  lzwc_datapath u_dp (
    .clk_i, .rst_ni, .in_beat_i, .dict_limit_i(dict_limit_q),
    .cmd_i(cmd), .status_o(status), .out_beat_o
  );
endmodule
`default_nettype wire

FILE: tb/sv/lzw_byte_compressor_test.sv
`timescale 1ns / 1ps
module lzw_byte_compressor_test;

  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned StuckLimit = 20000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [12:0]          cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  lzwc_pkg::in_beat_t   in_beat_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  lzwc_pkg::out_beat_t  out_beat_o;

  lzw_byte_compressor uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  always #4 clk_i = ~clk_i;

  // compressor state as predicted
  int unsigned     code_of_pair [logic [19:0]];
  logic [12:0]     free_code;
  logic [lzwc_pkg::CodeBits-1:0] held_prefix;
  logic            prefix_held;
  logic [12:0]     limit_reg;
  lzwc_pkg::out_beat_t expected_codes [$];

  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned stuck_cycles = 0;

  function automatic void push_code(logic [lzwc_pkg::CodeBits-1:0] code, logic last);
    lzwc_pkg::out_beat_t o;
    o.code_word = code;
    o.last_code = last;
    expected_codes = {expected_codes, o};
  endfunction

  // one byte through the predicted compressor
  function automatic void predict_codes(lzwc_pkg::in_beat_t b);
    logic [19:0] pair;
    int unsigned lim;
    lim = (limit_reg > lzwc_pkg::DictEntries) ? lzwc_pkg::DictEntries : limit_reg;
    pair = {held_prefix, b.data_byte};
    if (!prefix_held) begin
      held_prefix = lzwc_pkg::CodeBits'(b.data_byte);
      prefix_held = 1'b1;
    end else if (code_of_pair.exists(pair)) begin
      held_prefix = lzwc_pkg::CodeBits'(code_of_pair[pair]);
    end else begin
      push_code(held_prefix, 1'b0);
      if (free_code < lim) begin
        code_of_pair[pair] = free_code;
        free_code++;
      end
      held_prefix = lzwc_pkg::CodeBits'(b.data_byte);
    end
    if (b.end_of_stream) begin
      push_code(held_prefix, 1'b1);
      code_of_pair.delete();
      free_code = 13'(lzwc_pkg::ByteCodes);
      held_prefix = '0;
      prefix_held = 1'b0;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    lzwc_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected code: expected none, actual %0d last %0b",
                 $time, out_beat_o.code_word, out_beat_o.last_code);
        errors++;
      end else begin
        want = expected_codes.pop_front();
        if (out_beat_o.code_word !== want.code_word) begin
          $display("%0t: code_word mismatch: expected %0d, actual %0d",
                   $time, want.code_word, out_beat_o.code_word);
          errors++;
        end
        if (out_beat_o.last_code !== want.last_code) begin
          $display("%0t: last_code mismatch: expected %0b, actual %0b",
                   $time, want.last_code, out_beat_o.last_code);
          errors++;
        end
      end
    end
  end

  // receiver: random stall, or a long hold when asked
  always @(negedge clk_i) begin
    static int unsigned seen = 0;
    static int unsigned hold_left = 0;
    if (seen != hold_requests) begin
      seen = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("FAIL lzw_byte_compressor");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_beat(logic [7:0] data, logic eos);
    lzwc_pkg::in_beat_t b;
    b.data_byte = data;
    b.end_of_stream = eos;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_codes(b);
  endtask

  task automatic go_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    go_quiet();
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [12:0] lim);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= lim;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limit_reg = lim;
  endtask

  // one stream, bytes drawn from a narrow or a full alphabet
  task automatic send_stream(int unsigned len, bit narrow, bit close_it);
    logic [7:0] base;
    logic [7:0] d;
    base = 8'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      d = narrow ? base ^ 8'($urandom_range(0, 3)) : 8'($urandom);
      send_beat(d, close_it && (i == len - 1));
    end
  endtask

  task automatic test_directed();
    send_beat(8'h00, 1'b1);            // one-byte streams
    send_beat(8'hff, 1'b1);
    for (int i = 0; i < 9; i++) send_beat((i % 2) ? 8'h41 : 8'h42, 1'b0);
    send_beat(8'h55, 1'b1);            // miss on the final byte
    send_beat(8'haa, 1'b0);            // repeated byte, miss on the final byte
    send_beat(8'haa, 1'b0);
    send_beat(8'haa, 1'b0);
    send_beat(8'haa, 1'b1);
  endtask

  task automatic test_limits();
    set_limit(13'd0);                  // no entries ever
    send_stream(12, 1'b1, 1'b1);
    set_limit(13'd257);
    send_stream(20, 1'b1, 1'b1);
    set_limit(13'h1fff);
    send_stream(30, 1'b1, 1'b0);
    set_limit(13'd258);                // lowered mid-stream
    send_stream(30, 1'b1, 1'b1);
    set_limit(13'd300);
    send_stream(150, 1'b1, 1'b1);
    set_limit(13'd4096);
  endtask

  task automatic test_random(int unsigned items, int unsigned idle, int unsigned stall);
    int unsigned sent;
    int unsigned len;
    send_idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 25);
      send_stream(len, $urandom_range(0, 3) != 0, $urandom_range(0, 7) != 0);
      sent += len;
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    send_stream(60, 1'b0, 1'b1);
  endtask

  task automatic test_pause();
    send_stream(20, 1'b1, 1'b0);
    go_quiet();
    while (expected_codes.size() != 0) @(posedge clk_i);
    send_stream(20, 1'b1, 1'b1);
  endtask

  initial begin
    free_code = 13'(lzwc_pkg::ByteCodes);
    held_prefix = '0;
    prefix_held = 1'b0;
    limit_reg = 13'd4096;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_limits();
    test_random(200, 0, 0);
    test_random(300, 80, 0);
    test_random(300, 0, 80);
    set_limit(13'd400);
    test_random(300, 28, 28);
    set_limit(13'd4096);
    test_backpressure();
    test_pause();
    test_random(100, 0, 0);

    wait_drained();
    if (errors == 0 && expected_codes.size() == 0) begin
      $display("PASS lzw_byte_compressor");
    end else begin
      $display("FAIL lzw_byte_compressor");
    end
    $finish;
  end
endmodule

FILE: filelist.f
design/lzwc_pkg.sv
design/lzwc_datapath.sv
design/lzwc_ctrl.sv
design/lzw_byte_compressor.sv
tb/sv/lzw_byte_compressor_test.sv
